[sv/assert_macros.svh]
// Shared assertion shorthands.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/mpbc_pkg.sv]
`timescale 1ns / 1ps
package mpbc_pkg;

	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = 32 / DIV_STEP;
	localparam int IN_W       = 96;
	localparam int OUT_W      = 104;
	localparam int ADDR_W     = 6;

	localparam logic [7:0] CHECK_SEED = 8'hF8;
	localparam logic [7:0] SIZE_XOR   = 8'h3D;

	typedef enum logic [2:0] {
		REG_DIRECTION = 3'd0,
		REG_MOD_A     = 3'd1,
		REG_MOD_B     = 3'd2,
		REG_MUL_A     = 3'd3,
		REG_MUL_B     = 3'd4,
		REG_MASK_A    = 3'd5,
		REG_MASK_B    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic             dir;
		logic [63:0]      blk;
		logic [7:0]       cs;
		logic [7:0]       size;
		logic [7:0]       t9;
		logic [7:0]       t10;
		logic [3:0][31:0] rdec;
		logic [3:0][31:0] res;
	} item_t;

	function automatic logic [31:0] pick(logic [63:0] pa, logic [63:0] pb, logic [1:0] n);
		logic [63:0] p;
		p = n[1] ? pb : pa;
		return n[0] ? p[63:32] : p[31:0];
	endfunction

	// one restoring remainder step: shift in a bit, subtract if it fits
	function automatic logic [31:0] rem_step(logic [31:0] rem, logic b, logic [31:0] m);
		logic [32:0] t;
		t = {rem, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[31:0];
	endfunction

endpackage

[sv/mpbc_mulmod.sv]
`timescale 1ns / 1ps
module mpbc_mulmod (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        in_x,
	input  logic [31:0]        in_k,
	input  logic [31:0]        in_m,
	input  mpbc_pkg::item_t    in_item,
	output logic               out_valid,
	output logic [31:0]        out_mm,
	output mpbc_pkg::item_t    out_item
);

	localparam int STAGES = mpbc_pkg::DIV_STAGES;
	localparam int STEP   = mpbc_pkg::DIV_STEP;

	logic            vld_s1;
	logic [31:0]     prod_s1;
	logic [31:0]     mod_s1;
	mpbc_pkg::item_t item_s1;

	// divider stages, one entry per stage
	logic            vld_sd  [STAGES];
	logic [31:0]     rem_sd  [STAGES];
	logic [31:0]     prod_sd [STAGES];
	logic [31:0]     mod_sd  [STAGES];
	mpbc_pkg::item_t item_sd [STAGES];

	logic [63:0] prod_full;
	assign prod_full = in_x * in_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_full[31:0];
			mod_s1  <= in_m;
			item_s1 <= in_item;
		end
	end

	for (genvar j = 0; j < STAGES; j++) begin : g_div
		logic            vld_in;
		logic [31:0]     rem_in;
		logic [31:0]     prod_in;
		logic [31:0]     mod_in;
		mpbc_pkg::item_t item_in;
		logic [31:0]     rem_nx;

		if (j == 0) begin : g_first
			assign vld_in  = vld_s1;
			assign rem_in  = '0;
			assign prod_in = prod_s1;
			assign mod_in  = mod_s1;
			assign item_in = item_s1;
		end else begin : g_next
			assign vld_in  = vld_sd[j-1];
			assign rem_in  = rem_sd[j-1];
			assign prod_in = prod_sd[j-1];
			assign mod_in  = mod_sd[j-1];
			assign item_in = item_sd[j-1];
		end

		always_comb begin
			rem_nx = rem_in;
			for (int b = 0; b < STEP; b++) begin
				rem_nx = mpbc_pkg::rem_step(rem_nx, prod_in[31 - STEP*j - b], mod_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j] <= 1'b0;
			end else if (en) begin
				vld_sd[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j]  <= rem_nx;
				prod_sd[j] <= prod_in;
				mod_sd[j]  <= mod_in;
				item_sd[j] <= item_in;
			end
		end
	end

	// zero modulus passes the product through
	assign out_valid = vld_sd[STAGES-1];
	assign out_mm    = (mod_sd[STAGES-1] == '0) ? prod_sd[STAGES-1] : rem_sd[STAGES-1];
	assign out_item  = item_sd[STAGES-1];

endmodule

[sv/mpbc_outq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpbc_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	input  logic [mpbc_pkg::OUT_W-1:0] push_data,
	output logic                       en,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [mpbc_pkg::OUT_W-1:0] m_tdata
);

	logic [mpbc_pkg::OUT_W-1:0] mem_q [2];
	logic                       wr_q;
	logic                       rd_q;
	logic [1:0]                 cnt_q;
	logic                       push;
	logic                       pop;

	assign en       = (cnt_q != 2'd2) || m_tready;
	assign push     = en && push_valid;
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "output queue count out of range")
	`ASSERT_CLK(a_cnt_up, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "queue count lost a push")
	`ASSERT_CLK(a_ptr_gap, clk, arst_n, (cnt_q == 2'd1) |-> (wr_q != rd_q), "queue pointers disagree with count")

endmodule

[sv/modulus_packet_block_cipher_unit.sv]
`timescale 1ns / 1ps
// Modulus packet block cipher, one 8-byte plain / 11-byte cipher block per request.
// Input stream (s_t*): one request per block; tdata holds block_low, block_high
//   (cipher bytes 8..10, decrypt only) and plain_size (encrypt only).
// Output stream (m_t*): one request per block; tdata holds result_low,
//   result_high, recovered_size and checksum_ok.
// APB port: direction and the modulus, multiplier and mask pairs at 8*index.
//   Registers must be written only while no block is in flight; not enforced here.
// Pipeline: input accept to m_tvalid runs through one unpack stage, then four
//   multiply-modulo units of 17 stages each: one multiplier stage and sixteen
//   two-bit restoring remainder stages, then the output queue write; the word
//   chain sets this depth.
// Throughput: one block per cycle when not stalled (see Stall); a two-entry output
//   queue lets the pipeline keep accepting while a result waits.
// Stall: when the queue is full and m_tready is low, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
// Reset: all registers read zero, pipeline and queue empty.
module modulus_packet_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // block_low[63:0], block_high[87:64], plain_size[95:88]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [103:0] m_tdata,  // result_low[63:0], result_high[87:64],
	                               // recovered_size[95:88], checksum_ok[96], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// config registers
	logic        dir_q;
	logic [63:0] mod_a_q, mod_b_q, mul_a_q, mul_b_q, mask_a_q, mask_b_q;
	mpbc_pkg::reg_idx_t reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = mpbc_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= 1'b0;
			mod_a_q  <= '0;
			mod_b_q  <= '0;
			mul_a_q  <= '0;
			mul_b_q  <= '0;
			mask_a_q <= '0;
			mask_b_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				mpbc_pkg::REG_DIRECTION: dir_q    <= pwdata[0];
				mpbc_pkg::REG_MOD_A:     mod_a_q  <= pwdata;
				mpbc_pkg::REG_MOD_B:     mod_b_q  <= pwdata;
				mpbc_pkg::REG_MUL_A:     mul_a_q  <= pwdata;
				mpbc_pkg::REG_MUL_B:     mul_b_q  <= pwdata;
				mpbc_pkg::REG_MASK_A:    mask_a_q <= pwdata;
				mpbc_pkg::REG_MASK_B:    mask_b_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mpbc_pkg::REG_DIRECTION: prdata = {63'b0, dir_q};
			mpbc_pkg::REG_MOD_A:     prdata = mod_a_q;
			mpbc_pkg::REG_MOD_B:     prdata = mod_b_q;
			mpbc_pkg::REG_MUL_A:     prdata = mul_a_q;
			mpbc_pkg::REG_MUL_B:     prdata = mul_b_q;
			mpbc_pkg::REG_MASK_A:    prdata = mask_a_q;
			mpbc_pkg::REG_MASK_B:    prdata = mask_b_q;
			default:                 prdata = '0;
		endcase
	end

	logic en;
	assign s_tready = en;

	// unpack stage: plain checksum, cipher bit stream split and xor chain undone
	logic [63:0]     in_blk;
	logic [23:0]     in_hi;
	logic [71:0]     stream;
	logic [7:0]      in_cs;
	logic [3:0][31:0] v;
	mpbc_pkg::item_t item_nx;

	assign in_blk = s_tdata[63:0];
	assign in_hi  = s_tdata[87:64];
	assign stream = {in_blk[7:0], in_blk[15:8], in_blk[23:16], in_blk[31:24],
	                 in_blk[39:32], in_blk[47:40], in_blk[55:48], in_blk[63:56], in_hi[7:0]};

	always_comb begin
		logic [17:0] c;
		in_cs = mpbc_pkg::CHECK_SEED;
		for (int k = 0; k < 8; k++) begin
			in_cs = in_cs ^ in_blk[8*k +: 8];
		end
		for (int n = 0; n < 4; n++) begin
			c    = stream[71 - 18*n -: 18];
			v[n] = {14'b0, c[1], c[0], c[9:2], c[17:10]};
		end
		item_nx         = '0;
		item_nx.dir     = dir_q;
		item_nx.blk     = in_blk;
		item_nx.cs      = in_cs;
		item_nx.size    = s_tdata[95:88];
		item_nx.t9      = in_hi[15:8];
		item_nx.t10     = in_hi[23:16];
		item_nx.rdec[3] = v[3];
		item_nx.rdec[2] = v[2] ^ mpbc_pkg::pick(mask_a_q, mask_b_q, 2'd2)
		                  ^ {16'b0, item_nx.rdec[3][15:0]};
		item_nx.rdec[1] = v[1] ^ mpbc_pkg::pick(mask_a_q, mask_b_q, 2'd1)
		                  ^ {16'b0, item_nx.rdec[2][15:0]};
		item_nx.rdec[0] = v[0] ^ mpbc_pkg::pick(mask_a_q, mask_b_q, 2'd0)
		                  ^ {16'b0, item_nx.rdec[1][15:0]};
	end

	logic            vld_s1;
	mpbc_pkg::item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_nx;
		end
	end

	// four chained multiply-modulo units, one per 16-bit word
	logic            u_vin  [4];
	logic [31:0]     u_x    [4];
	mpbc_pkg::item_t u_iin  [4];
	logic            u_vout [4];
	logic [31:0]     u_mm   [4];
	mpbc_pkg::item_t u_iout [4];

	for (genvar n = 0; n < 4; n++) begin : g_word
		logic [31:0] prev;
		if (n == 0) begin : g_head
			assign u_vin[n] = vld_s1;
			assign u_iin[n] = item_s1;
			assign prev     = '0;
		end else begin : g_link
			always_comb begin
				u_iin[n]          = u_iout[n-1];
				u_iin[n].res[n-1] = u_mm[n-1];
			end
			assign u_vin[n] = u_vout[n-1];
			assign prev     = {16'b0, u_mm[n-1][15:0]};
		end

		assign u_x[n] = u_iin[n].dir ? u_iin[n].rdec[n]
		              : (mpbc_pkg::pick(mask_a_q, mask_b_q, 2'(n))
		                 ^ {16'b0, u_iin[n].blk[16*n +: 16]} ^ prev);

		mpbc_mulmod u_mulmod (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (u_vin[n]),
			.in_x      (u_x[n]),
			.in_k      (mpbc_pkg::pick(mul_a_q, mul_b_q, 2'(n))),
			.in_m      (mpbc_pkg::pick(mod_a_q, mod_b_q, 2'(n))),
			.in_item   (u_iin[n]),
			.out_valid (u_vout[n]),
			.out_mm    (u_mm[n]),
			.out_item  (u_iout[n])
		);
	end

	// result assembly
	mpbc_pkg::item_t            fin;
	logic [mpbc_pkg::OUT_W-1:0] res_data;

	always_comb begin
		logic [3:0][31:0] rr;
		logic [71:0]      ct;
		logic [3:0][31:0] d;
		logic [63:0]      pt;
		logic [7:0]       cs;
		logic [7:0]       ct9;
		fin        = u_iout[3];
		fin.res[3] = u_mm[3];
		for (int n = 0; n < 4; n++) begin
			if (n < 3) begin
				rr[n] = fin.res[n] ^ mpbc_pkg::pick(mask_a_q, mask_b_q, 2'(n))
				        ^ {16'b0, fin.res[(n+1)%4][15:0]};
			end else begin
				rr[n] = fin.res[n];
			end
			ct[71 - 18*n -: 18] = {rr[n][7:0], rr[n][15:8], rr[n][17], rr[n][16]};
			d[n] = fin.res[n] ^ mpbc_pkg::pick(mask_a_q, mask_b_q, 2'(n))
			       ^ ((n == 0) ? 32'b0 : {16'b0, fin.rdec[(n+3)%4][15:0]});
			pt[16*n +: 16] = d[n][15:0];
		end
		cs = mpbc_pkg::CHECK_SEED;
		for (int k = 0; k < 8; k++) begin
			cs = cs ^ pt[8*k +: 8];
		end
		ct9 = fin.cs ^ fin.size ^ mpbc_pkg::SIZE_XOR;
		if (fin.dir) begin
			res_data = {7'b0, (cs == fin.t10), fin.t9 ^ fin.t10 ^ mpbc_pkg::SIZE_XOR,
			            24'b0, pt};
		end else begin
			res_data = {7'b0, 1'b1, 8'b0, fin.cs, ct9, ct[7:0],
			            ct[15:8], ct[23:16], ct[31:24], ct[39:32],
			            ct[47:40], ct[55:48], ct[63:56], ct[71:64]};
		end
	end

	mpbc_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (u_vout[3]),
		.push_data  (res_data),
		.en         (en),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
